/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the RTL; compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Clocked property, disabled while reset is asserted (active low).
`define ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Clocked property, checked during reset as well.
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`else
`define ASSERT_RST(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

/* rtl/core/crcv_pkg.sv */
`timescale 1ns / 1ps
package crcv_pkg;

    localparam int TYPE_COUNT  = 5;
    localparam int MAX_PAYLOAD = 1024;

    localparam int CMD_W    = 2;
    localparam int TYPE_W   = 3;
    localparam int LEN_W    = 11;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int MASK_W   = 5;
    localparam int CRC_W    = 16;

    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

    localparam logic [MASK_W-1:0] FULL_MASK = MASK_W'((1 << TYPE_COUNT) - 1);
    localparam logic [LEN_W-1:0]  MAX_LEN   = LEN_W'(MAX_PAYLOAD);

    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BYTE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ABORT = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EEPROM = 2'd1;
    localparam logic [STATUS_W-1:0] ST_HEADER = 2'd2;
    localparam logic [STATUS_W-1:0] ST_CRC    = 2'd3;

    typedef struct packed {
        logic              all_valid;
        logic [MASK_W-1:0] valid_mask;
        logic [TYPE_W-1:0] done_type;
        logic [STATUS_W-1:0] status;
    } t_result;

endpackage

/* rtl/core/crcv_crc_byte.sv */
`timescale 1ns / 1ps
module crcv_crc_byte
    import crcv_pkg::*;
(
    input  logic [CRC_W-1:0]  i_crc,
    input  logic [BYTE_W-1:0] i_byte,
    output logic [CRC_W-1:0]  o_crc
);

    // Reflected CRC-16, one bit per step, LSB first.
    always_comb begin
        logic [CRC_W-1:0] c;
        c = i_crc ^ {{(CRC_W-BYTE_W){1'b0}}, i_byte};
        for (int i = 0; i < BYTE_W; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        o_crc = c;
    end

endmodule

/* rtl/core/crcv_core.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module crcv_core
    import crcv_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CRC_W-1:0]  i_cfg_data,
    input  logic              i_beat,
    input  logic [CMD_W-1:0]  i_cmd,
    input  logic [TYPE_W-1:0] i_record_type,
    input  logic [LEN_W-1:0]  i_payload_length,
    input  logic [BYTE_W-1:0] i_data_byte,
    output logic              o_res_valid,
    output t_result           o_res
);

    logic [CRC_W-1:0]  r_header_base;
    logic [LEN_W-1:0]  r_pos, n_pos;
    logic [CRC_W-1:0]  r_crc, n_crc;
    logic [BYTE_W-1:0] r_low, n_low;
    logic [TYPE_W-1:0] r_type, n_type;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [MASK_W-1:0] r_mask, n_mask;

    logic [CRC_W-1:0]  crc_upd;
    logic [LEN_W-1:0]  len_end;
    logic [CRC_W-1:0]  word_in;
    logic [CRC_W-1:0]  hdr_expect;
    logic [STATUS_W-1:0] res_status;
    logic [TYPE_W-1:0] res_type;

    crcv_crc_byte u_crc (
        .i_crc  (r_crc),
        .i_byte (i_data_byte),
        .o_crc  (crc_upd)
    );

    assign len_end    = r_len + LEN_W'(2);
    assign word_in    = {i_data_byte, r_low};
    assign hdr_expect = r_header_base | {{(CRC_W-TYPE_W){1'b0}}, r_type};

    always_comb begin
        n_pos       = r_pos;
        n_crc       = r_crc;
        n_low       = r_low;
        n_type      = r_type;
        n_len       = r_len;
        n_mask      = r_mask;
        o_res_valid = 1'b0;
        res_status  = ST_OK;
        res_type    = r_type;
        if (i_beat) begin
            unique case (i_cmd)
                CMD_CLEAR: begin
                    n_mask = '0;
                end
                CMD_ABORT: begin
                    o_res_valid = 1'b1;
                    res_status  = ST_EEPROM;
                    res_type    = (r_pos == '0) ? i_record_type : r_type;
                    n_pos       = '0;
                    n_crc       = CRC_INIT;
                end
                CMD_BYTE: begin
                    if (r_pos == '0) begin
                        n_type = i_record_type;
                        n_len  = (i_payload_length > MAX_LEN) ? MAX_LEN : i_payload_length;
                        n_low  = i_data_byte;
                        n_pos  = LEN_W'(1);
                    end else if (r_pos == LEN_W'(1)) begin
                        if (word_in != hdr_expect) begin
                            o_res_valid = 1'b1;
                            res_status  = ST_HEADER;
                            n_pos       = '0;
                        end else begin
                            n_pos = LEN_W'(2);
                        end
                        n_crc = CRC_INIT;
                    end else if (r_pos < len_end) begin
                        n_crc = crc_upd;
                        n_pos = r_pos + LEN_W'(1);
                    end else if (r_pos == len_end) begin
                        n_low = i_data_byte;
                        n_pos = r_pos + LEN_W'(1);
                    end else begin
                        o_res_valid = 1'b1;
                        n_pos       = '0;
                        n_crc       = CRC_INIT;
                        if (word_in != r_crc) begin
                            res_status = ST_CRC;
                        end else begin
                            res_status = ST_OK;
                            if (r_type < TYPE_W'(TYPE_COUNT)) begin
                                n_mask = r_mask | (MASK_W'(1) << r_type);
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_res.status     = res_status;
        o_res.done_type  = res_type;
        o_res.valid_mask = n_mask;
        o_res.all_valid  = ((n_mask & FULL_MASK) == FULL_MASK);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_base <= '0;
            r_pos         <= '0;
            r_crc         <= CRC_INIT;
            r_low         <= '0;
            r_type        <= '0;
            r_len         <= '0;
            r_mask        <= '0;
        end else begin
            if (i_cfg_we) begin
                r_header_base <= i_cfg_data;
            end
            r_pos  <= n_pos;
            r_crc  <= n_crc;
            r_low  <= n_low;
            r_type <= n_type;
            r_len  <= n_len;
            r_mask <= n_mask;
        end
    end

    // any finished or aborted record leaves the walker idle
    `ASSERT_RST(a_idle_after_result, i_clk, i_rst_n, o_res_valid |=> (r_pos == '0))
    // a clear beat never moves the record walker
    `ASSERT_RST(a_clear_keeps_pos, i_clk, i_rst_n,
        (i_beat && i_cmd == CMD_CLEAR) |=> $stable(r_pos))
    // the walker never runs past the trailing CRC byte
    `ASSERT_RST(a_pos_bound, i_clk, i_rst_n, r_pos <= (r_len + LEN_W'(3)))

endmodule

/* rtl/core/crcv_out_fifo.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module crcv_out_fifo
    import crcv_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_room,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    t_result    r_slot [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       pop;

    assign pop     = o_valid && i_ready;
    assign o_valid = (r_count != 2'd0);
    assign o_room  = (r_count != 2'd2);
    assign o_data  = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, pop};
        end
    end

    `ASSERT_RST(a_no_overflow, i_clk, i_rst_n, i_push |-> o_room)
    `ASSERT_RST(a_count_bound, i_clk, i_rst_n, r_count != 2'd3)
    `ASSERT_RST(a_fill_to_full, i_clk, i_rst_n,
        (i_push && !pop && r_count == 2'd1) |=> (r_count == 2'd2 && !o_room))

endmodule

/* rtl/core/crc16_record_validator.sv */
`timescale 1ns / 1ps
// Each result beat is registered into the result queue and offered on the m_axis side.
// Throughput: one input beat per cycle; a two-entry result queue keeps input flowing
// while the output is stalled, and s_axis_tready drops only when both entries are held.
// Reset (i_rst_n low, synchronous): walker idle, CRC 0xFFFF, mask and header_base zero,
// result queue empty.
module crc16_record_validator
    import crcv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,     // header_base
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // record_type[2:0], payload_length[13:3], data_byte[21:14]
    input  logic [1:0]  s_axis_tuser,   // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // done_type[2:0], valid_mask[7:3], all_valid[8]
    output logic [1:0]  m_axis_tuser    // status
);

    logic    beat;
    logic    res_valid;
    t_result res;
    t_result out_res;
    logic    room;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = room;
    assign beat          = s_axis_tvalid && room;

    crcv_core u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_valid),
        .i_cfg_data       (i_cfg_data),
        .i_beat           (beat),
        .i_cmd            (s_axis_tuser),
        .i_record_type    (s_axis_tdata[2:0]),
        .i_payload_length (s_axis_tdata[13:3]),
        .i_data_byte      (s_axis_tdata[21:14]),
        .o_res_valid      (res_valid),
        .o_res            (res)
    );

    crcv_out_fifo u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_room  (room),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (out_res)
    );

    assign m_axis_tuser = out_res.status;
    assign m_axis_tdata = {7'd0, out_res.all_valid, out_res.valid_mask, out_res.done_type};

endmodule
